/* src/crth_pkg.sv */
`default_nettype none
package crth_pkg;

   // Default width of the object index counter.
   localparam int OBJ_INDEX_BITS_DEFAULT = 16;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Input item kinds.
   localparam logic CMD_OBJECT   = 1'b0;
   localparam logic CMD_TRIANGLE = 1'b1;

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [2:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [2:0] CSR_DIR_X    = 3'd3;
   localparam logic [2:0] CSR_DIR_Y    = 3'd4;
   localparam logic [2:0] CSR_DIR_Z    = 3'd5;
   localparam logic [2:0] CSR_EPSILON  = 3'd6;

   // Reset values of the configuration registers.
   localparam logic signed [31:0] DIR_Z_RESET   = 32'sd65536;
   localparam logic [15:0]        EPSILON_RESET = 16'd1;

   // Width of the dot product accumulator and its results.
   localparam int ACC_BITS = 52;

   // Number of product steps in the back sequencer.
   localparam int          STEP_COUNT = 24;
   localparam logic [4:0]  STEP_LAST  = 5'(STEP_COUNT - 1);

   // Number of quotient bits produced by the distance divider.
   localparam int          DIV_BITS     = 31;
   localparam logic [4:0]  DIV_CNT_INIT = 5'(DIV_BITS - 1);

   typedef logic signed [31:0] q16_type;
   typedef q16_type [2:0]      vec3_type;
   typedef logic signed [ACC_BITS-1:0] acc_type;

   typedef struct packed {
      logic    cmd;
      q16_type vertex0_x;
      q16_type vertex0_y;
      q16_type vertex0_z;
      q16_type vertex1_x;
      q16_type vertex1_y;
      q16_type vertex1_z;
      q16_type vertex2_x;
      q16_type vertex2_y;
      q16_type vertex2_z;
      logic    last_item;
   } req_type;

   typedef struct packed {
      logic        hit_found;
      logic [30:0] hit_distance;
      logic [15:0] hit_object;
   } rsp_type;

   // Geometry of one queued item, already translated into edges.
   typedef struct packed {
      logic     is_tri;
      logic     last;
      vec3_type e1;
      vec3_type e2;
      vec3_type s;
   } geom_type;

   // Operand sources of the shared multiplier.
   typedef enum logic [4:0] {
      SRC_D0, SRC_D1, SRC_D2,
      SRC_E1_0, SRC_E1_1, SRC_E1_2,
      SRC_E2_0, SRC_E2_1, SRC_E2_2,
      SRC_S0, SRC_S1, SRC_S2,
      SRC_H0, SRC_H1, SRC_H2,
      SRC_Q0, SRC_Q1, SRC_Q2
   } src_type;

   // Destinations of a finished sum.
   typedef enum logic [3:0] {
      DST_H0, DST_H1, DST_H2,
      DST_Q0, DST_Q1, DST_Q2,
      DST_A, DST_NU, DST_NV, DST_NT
   } dst_type;

   typedef struct packed {
      src_type src_a;
      src_type src_b;
      logic    first;
      logic    sub;
      logic    last;
      dst_type dst;
   } step_type;

   // Microcode of the back: cross products h = d x e2, q = s x e1, then dots.
   function automatic step_type step_info(input logic [4:0] idx);
      step_type r;
      r = '{SRC_D0, SRC_D0, 1'b1, 1'b0, 1'b0, DST_A};
      case (idx)
         5'd0:  r = '{SRC_D1,   SRC_E2_2, 1'b1, 1'b0, 1'b0, DST_H0};
         5'd1:  r = '{SRC_D2,   SRC_E2_1, 1'b0, 1'b1, 1'b1, DST_H0};
         5'd2:  r = '{SRC_D2,   SRC_E2_0, 1'b1, 1'b0, 1'b0, DST_H1};
         5'd3:  r = '{SRC_D0,   SRC_E2_2, 1'b0, 1'b1, 1'b1, DST_H1};
         5'd4:  r = '{SRC_D0,   SRC_E2_1, 1'b1, 1'b0, 1'b0, DST_H2};
         5'd5:  r = '{SRC_D1,   SRC_E2_0, 1'b0, 1'b1, 1'b1, DST_H2};
         5'd6:  r = '{SRC_E1_0, SRC_H0,   1'b1, 1'b0, 1'b0, DST_A};
         5'd7:  r = '{SRC_E1_1, SRC_H1,   1'b0, 1'b0, 1'b0, DST_A};
         5'd8:  r = '{SRC_E1_2, SRC_H2,   1'b0, 1'b0, 1'b1, DST_A};
         5'd9:  r = '{SRC_S1,   SRC_E1_2, 1'b1, 1'b0, 1'b0, DST_Q0};
         5'd10: r = '{SRC_S2,   SRC_E1_1, 1'b0, 1'b1, 1'b1, DST_Q0};
         5'd11: r = '{SRC_S2,   SRC_E1_0, 1'b1, 1'b0, 1'b0, DST_Q1};
         5'd12: r = '{SRC_S0,   SRC_E1_2, 1'b0, 1'b1, 1'b1, DST_Q1};
         5'd13: r = '{SRC_S0,   SRC_E1_1, 1'b1, 1'b0, 1'b0, DST_Q2};
         5'd14: r = '{SRC_S1,   SRC_E1_0, 1'b0, 1'b1, 1'b1, DST_Q2};
         5'd15: r = '{SRC_S0,   SRC_H0,   1'b1, 1'b0, 1'b0, DST_NU};
         5'd16: r = '{SRC_S1,   SRC_H1,   1'b0, 1'b0, 1'b0, DST_NU};
         5'd17: r = '{SRC_S2,   SRC_H2,   1'b0, 1'b0, 1'b1, DST_NU};
         5'd18: r = '{SRC_D0,   SRC_Q0,   1'b1, 1'b0, 1'b0, DST_NV};
         5'd19: r = '{SRC_D1,   SRC_Q1,   1'b0, 1'b0, 1'b0, DST_NV};
         5'd20: r = '{SRC_D2,   SRC_Q2,   1'b0, 1'b0, 1'b1, DST_NV};
         5'd21: r = '{SRC_E2_0, SRC_Q0,   1'b1, 1'b0, 1'b0, DST_NT};
         5'd22: r = '{SRC_E2_1, SRC_Q1,   1'b0, 1'b0, 1'b0, DST_NT};
         5'd23: r = '{SRC_E2_2, SRC_Q2,   1'b0, 1'b0, 1'b1, DST_NT};
         default: r = '{SRC_D0, SRC_D0, 1'b1, 1'b0, 1'b0, DST_A};
      endcase
      return r;
   endfunction

   // Saturating Q16.16 addition and subtraction.
   function automatic q16_type add_sat(input q16_type x, input q16_type y);
      logic signed [32:0] sum;
      q16_type r;
      sum = {x[31], x} + {y[31], y};
      if (sum[32] != sum[31]) begin
         r = sum[32] ? q16_type'(32'h8000_0000) : q16_type'(32'h7FFF_FFFF);
      end else begin
         r = sum[31:0];
      end
      return r;
   endfunction

   function automatic q16_type sub_sat(input q16_type x, input q16_type y);
      logic signed [32:0] dif;
      q16_type r;
      dif = {x[31], x} - {y[31], y};
      if (dif[32] != dif[31]) begin
         r = dif[32] ? q16_type'(32'h8000_0000) : q16_type'(32'h7FFF_FFFF);
      end else begin
         r = dif[31:0];
      end
      return r;
   endfunction

   // Saturates an accumulator value to a Q16.16 word.
   function automatic q16_type sat_acc(input acc_type x);
      q16_type r;
      if (x > acc_type'(64'sh7FFF_FFFF)) begin
         r = q16_type'(32'h7FFF_FFFF);
      end else if (x < -acc_type'(64'sh8000_0000)) begin
         r = q16_type'(32'h8000_0000);
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* src/crth_fifo.sv */
`default_nettype none
module crth_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] head_data,
   output logic                  full,
   output logic                  empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == CNT_BITS'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_data = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

/* src/crth_front.sv */
`default_nettype none
module crth_front
   import crth_pkg::*;
#(
   parameter int OBJECT_INDEX_BITS = OBJ_INDEX_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire req_type                      req_data,
   input  wire vec3_type                     origin,
   input  wire logic                         queue_full,
   output logic                              push,
   output geom_type                          push_geom,
   output logic      [OBJECT_INDEX_BITS-1:0] push_obj
);

   vec3_type                     pos_ff, pos_in;
   logic [OBJECT_INDEX_BITS-1:0] obj_cnt_ff, obj_cnt_in;
   vec3_type                     v0, v1, v2;
   logic                         accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign push      = accept;
   assign push_obj  = obj_cnt_ff;

   // Translate the triangle by the object position and form the edges.
   always_comb begin
      v0[0] = add_sat(req_data.vertex0_x, pos_ff[0]);
      v0[1] = add_sat(req_data.vertex0_y, pos_ff[1]);
      v0[2] = add_sat(req_data.vertex0_z, pos_ff[2]);
      v1[0] = add_sat(req_data.vertex1_x, pos_ff[0]);
      v1[1] = add_sat(req_data.vertex1_y, pos_ff[1]);
      v1[2] = add_sat(req_data.vertex1_z, pos_ff[2]);
      v2[0] = add_sat(req_data.vertex2_x, pos_ff[0]);
      v2[1] = add_sat(req_data.vertex2_y, pos_ff[1]);
      v2[2] = add_sat(req_data.vertex2_z, pos_ff[2]);
      push_geom.is_tri = (req_data.cmd == CMD_TRIANGLE);
      push_geom.last   = req_data.last_item;
      for (int i = 0; i < 3; i++) begin
         push_geom.e1[i] = sub_sat(v1[i], v0[i]);
         push_geom.e2[i] = sub_sat(v2[i], v0[i]);
         push_geom.s[i]  = sub_sat(origin[i], v0[i]);
      end
   end

   // Object state: a start item loads the position, the last item clears it.
   always_comb begin
      pos_in     = pos_ff;
      obj_cnt_in = obj_cnt_ff;
      if (accept) begin
         if (req_data.cmd == CMD_OBJECT) begin
            pos_in[0]  = req_data.vertex0_x;
            pos_in[1]  = req_data.vertex0_y;
            pos_in[2]  = req_data.vertex0_z;
            obj_cnt_in = obj_cnt_ff + 1'b1;
         end
         if (req_data.last_item) begin
            pos_in     = '0;
            obj_cnt_in = '1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         obj_cnt_ff <= '1;
      end else begin
         pos_ff     <= pos_in;
         obj_cnt_ff <= obj_cnt_in;
      end
   end

endmodule
`default_nettype wire

/* src/crth_back.sv */
`default_nettype none
module crth_back
   import crth_pkg::*;
#(
   parameter int OBJECT_INDEX_BITS = OBJ_INDEX_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         queue_empty,
   input  wire geom_type                     head_geom,
   input  wire logic [OBJECT_INDEX_BITS-1:0] head_obj,
   output logic                              pop,
   input  wire vec3_type                     dir,
   input  wire logic [15:0]                  epsilon,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output rsp_type                           rsp_data
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MUL   = 6'b000010,
      ST_ACC   = 6'b000100,
      ST_CHECK = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_FINAL = 6'b100000
   } state_type;

   state_type                    state_ff, state_in;
   logic [4:0]                   step_ff, step_in;
   vec3_type                     e1_ff, e1_in, e2_ff, e2_in, s_ff, s_in;
   vec3_type                     h_ff, h_in, q_ff, q_in;
   acc_type                      a_ff, a_in, nu_ff, nu_in, nv_ff, nv_in, nt_ff, nt_in;
   acc_type                      acc_ff, acc_in;
   logic signed [47:0]           prod_ff, prod_in;
   logic                         last_ff, last_in;
   logic [OBJECT_INDEX_BITS-1:0] obj_ff, obj_in;
   logic                         cand_ff, cand_in;
   logic [30:0]                  t_ff, t_in;
   logic [ACC_BITS-1:0]          ua_ff, ua_in, rem_ff, rem_in;
   logic [30:0]                  num_ff, num_in;
   logic [4:0]                   cnt_ff, cnt_in;
   logic [31:0]                  best_dist_ff, best_dist_in;
   logic [OBJECT_INDEX_BITS-1:0] best_obj_ff, best_obj_in;
   logic                         any_hit_ff, any_hit_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_ff, rsp_in;

   step_type            step;
   q16_type             op_a, op_b;
   logic signed [63:0]  product;
   acc_type             acc_new;
   q16_type             acc_sat;
   acc_type             a_abs, nu_p, nv_p, nt_p, nt_sh;
   logic                reject, saturate;
   logic [ACC_BITS:0]   r2;
   logic                ge;
   logic                take;
   logic [31:0]         obj_wide;

   // Operand selection for the shared multiplier.
   function automatic q16_type pick(input src_type sel, input vec3_type d,
                                    input vec3_type e1, input vec3_type e2,
                                    input vec3_type s, input vec3_type h,
                                    input vec3_type q);
      q16_type r;
      unique case (sel)
         SRC_D0:   r = d[0];
         SRC_D1:   r = d[1];
         SRC_D2:   r = d[2];
         SRC_E1_0: r = e1[0];
         SRC_E1_1: r = e1[1];
         SRC_E1_2: r = e1[2];
         SRC_E2_0: r = e2[0];
         SRC_E2_1: r = e2[1];
         SRC_E2_2: r = e2[2];
         SRC_S0:   r = s[0];
         SRC_S1:   r = s[1];
         SRC_S2:   r = s[2];
         SRC_H0:   r = h[0];
         SRC_H1:   r = h[1];
         SRC_H2:   r = h[2];
         SRC_Q0:   r = q[0];
         SRC_Q1:   r = q[1];
         SRC_Q2:   r = q[2];
         default:  r = '0;
      endcase
      return r;
   endfunction

   assign step    = step_info(step_ff);
   assign op_a    = pick(step.src_a, dir, e1_ff, e2_ff, s_ff, h_ff, q_ff);
   assign op_b    = pick(step.src_b, dir, e1_ff, e2_ff, s_ff, h_ff, q_ff);
   assign product = 64'(op_a) * 64'(op_b);

   // Accumulator: the first term loads, later terms add or subtract.
   always_comb begin
      if (step.first) begin
         acc_new = acc_type'(prod_ff);
      end else if (step.sub) begin
         acc_new = acc_ff - acc_type'(prod_ff);
      end else begin
         acc_new = acc_ff + acc_type'(prod_ff);
      end
   end
   assign acc_sat = sat_acc(acc_new);

   // Sign fold and bound tests on the numerators.
   always_comb begin
      if (a_ff < 0) begin
         a_abs = -a_ff;
         nu_p  = -nu_ff;
         nv_p  = -nv_ff;
         nt_p  = -nt_ff;
      end else begin
         a_abs = a_ff;
         nu_p  = nu_ff;
         nv_p  = nv_ff;
         nt_p  = nt_ff;
      end
      nt_sh    = nt_p >>> 15;
      reject   = (a_ff == '0) || (a_abs < acc_type'({1'b0, epsilon})) ||
                 (nu_p < 0) || (nu_p > a_abs) || (nv_p < 0) ||
                 ((nu_p + nv_p) > a_abs) || (nt_p <= 0);
      saturate = (nt_sh >= a_abs);
   end

   // One restoring division step per cycle.
   assign r2 = {rem_ff, num_ff[30]};
   assign ge = (r2 >= {1'b0, ua_ff});

   // Nearest hit selection; ties keep the earlier hit.
   assign take     = cand_ff && ({1'b0, t_ff} > {16'b0, epsilon}) &&
                     ({1'b0, t_ff} < best_dist_ff);
   assign obj_wide = 32'(take ? obj_ff : best_obj_ff);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      s_in         = s_ff;
      h_in         = h_ff;
      q_in         = q_ff;
      a_in         = a_ff;
      nu_in        = nu_ff;
      nv_in        = nv_ff;
      nt_in        = nt_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      last_in      = last_ff;
      obj_in       = obj_ff;
      cand_in      = cand_ff;
      t_in         = t_ff;
      ua_in        = ua_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      cnt_in       = cnt_ff;
      best_dist_in = best_dist_ff;
      best_obj_in  = best_obj_ff;
      any_hit_in   = any_hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               pop     = 1'b1;
               e1_in   = head_geom.e1;
               e2_in   = head_geom.e2;
               s_in    = head_geom.s;
               last_in = head_geom.last;
               obj_in  = head_obj;
               cand_in = 1'b0;
               step_in = '0;
               state_in = head_geom.is_tri ? ST_MUL : ST_FINAL;
            end
         end
         ST_MUL: begin
            prod_in  = product[63:16];
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in = acc_new;
            if (step.last) begin
               case (step.dst)
                  DST_H0:  h_in[0] = acc_sat;
                  DST_H1:  h_in[1] = acc_sat;
                  DST_H2:  h_in[2] = acc_sat;
                  DST_Q0:  q_in[0] = acc_sat;
                  DST_Q1:  q_in[1] = acc_sat;
                  DST_Q2:  q_in[2] = acc_sat;
                  DST_A:   a_in    = acc_new;
                  DST_NU:  nu_in   = acc_new;
                  DST_NV:  nv_in   = acc_new;
                  DST_NT:  nt_in   = acc_new;
                  default: a_in    = a_ff;
               endcase
            end
            if (step_ff == STEP_LAST) begin
               state_in = ST_CHECK;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_CHECK: begin
            ua_in  = a_abs;
            rem_in = nt_sh;
            num_in = {nt_p[14:0], 16'b0};
            cnt_in = DIV_CNT_INIT;
            t_in   = '0;
            if (reject) begin
               cand_in  = 1'b0;
               state_in = ST_FINAL;
            end else if (saturate) begin
               cand_in  = 1'b1;
               t_in     = '1;
               state_in = ST_FINAL;
            end else begin
               cand_in  = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = ge ? ACC_BITS'(r2 - {1'b0, ua_ff}) : r2[ACC_BITS-1:0];
            t_in   = {t_ff[29:0], ge};
            num_in = {num_ff[29:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (!last_ff) begin
               if (take) begin
                  best_dist_in = {1'b0, t_ff};
                  best_obj_in  = obj_ff;
                  any_hit_in   = 1'b1;
               end
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               // Report the query and clear it for the next one.
               rsp_valid_in = 1'b1;
               if (take || any_hit_ff) begin
                  rsp_in.hit_found    = 1'b1;
                  rsp_in.hit_distance = take ? t_ff : best_dist_ff[30:0];
                  rsp_in.hit_object   = obj_wide[15:0];
               end else begin
                  rsp_in = '0;
               end
               best_dist_in = '1;
               best_obj_in  = '0;
               any_hit_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         cnt_ff       <= '0;
         best_dist_ff <= '1;
         best_obj_ff  <= '0;
         any_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         best_dist_ff <= best_dist_in;
         best_obj_ff  <= best_obj_in;
         any_hit_ff   <= any_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working data of the item in progress.
   always_ff @(posedge clock) begin
      e1_ff   <= e1_in;
      e2_ff   <= e2_in;
      s_ff    <= s_in;
      h_ff    <= h_in;
      q_ff    <= q_in;
      a_ff    <= a_in;
      nu_ff   <= nu_in;
      nv_ff   <= nv_in;
      nt_ff   <= nt_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      last_ff <= last_in;
      obj_ff  <= obj_in;
      cand_ff <= cand_in;
      t_ff    <= t_in;
      ua_ff   <= ua_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      rsp_ff  <= rsp_in;
   end

endmodule
`default_nettype wire

/* src/closest_ray_triangle_hit.sv */
// Nearest ray/triangle hit over a stream of objects and triangles.
// The ray origin, direction and epsilon are written through the csr_ port;
// the user must write them only while the block is idle, as the block itself
// does not enforce it. Items enter on req_ (valid/ready): an object start
// sets the position and index for the following triangles, a triangle is
// tested against the ray. The item marked last_item gives one result on
// rsp_ (valid/ready): hit flag, nearest distance and owning object index.
// The front translates each triangle into edges in the accepting cycle and
// places it in a two-entry queue. The back runs the test on one shared
// 32x32 multiplier over 24 products, then divides one quotient bit per
// cycle. The result is registered. The back takes a new item from the
// queue only when it is through with the last one. Reset clears the query
// state, the queue and the result valid flag and loads the register
// defaults. When the receiver stalls, the result is held, the back waits
// on the next last item and the queue fills, after which req_ready falls.
`default_nettype none
module closest_ray_triangle_hit
   import crth_pkg::*;
#(
   parameter int OBJECT_INDEX_BITS = OBJ_INDEX_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int ENTRY_BITS = $bits(geom_type) + OBJECT_INDEX_BITS;

   vec3_type                     origin_ff, dir_ff;
   logic [15:0]                  epsilon_ff;
   logic                         push, pop, queue_full, queue_empty;
   geom_type                     push_geom, head_geom;
   logic [OBJECT_INDEX_BITS-1:0] push_obj, head_obj;
   logic [ENTRY_BITS-1:0]        head_entry;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff  <= '0;
         dir_ff     <= {DIR_Z_RESET, q16_type'(0), q16_type'(0)};
         epsilon_ff <= EPSILON_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ORIGIN_X: origin_ff[0] <= csr_wdata;
            CSR_ORIGIN_Y: origin_ff[1] <= csr_wdata;
            CSR_ORIGIN_Z: origin_ff[2] <= csr_wdata;
            CSR_DIR_X:    dir_ff[0]    <= csr_wdata;
            CSR_DIR_Y:    dir_ff[1]    <= csr_wdata;
            CSR_DIR_Z:    dir_ff[2]    <= csr_wdata;
            CSR_EPSILON:  epsilon_ff   <= csr_wdata[15:0];
            default:      epsilon_ff   <= epsilon_ff;
         endcase
      end
   end

   crth_front #(
      .OBJECT_INDEX_BITS(OBJECT_INDEX_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .origin     (origin_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_geom  (push_geom),
      .push_obj   (push_obj)
   );

   crth_fifo #(
      .WIDTH(ENTRY_BITS),
      .DEPTH(QUEUE_DEPTH_DEFAULT)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_geom, push_obj}),
      .pop       (pop),
      .head_data (head_entry),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   assign head_geom = head_entry[ENTRY_BITS-1:OBJECT_INDEX_BITS];
   assign head_obj  = head_entry[OBJECT_INDEX_BITS-1:0];

   crth_back #(
      .OBJECT_INDEX_BITS(OBJECT_INDEX_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_geom   (head_geom),
      .head_obj    (head_obj),
      .pop         (pop),
      .dir         (dir_ff),
      .epsilon     (epsilon_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire
